[design/ole_pkg.sv]
package ole_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned MATCH_W   = 5;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned IN_FLD_W  = CMD_W + DATA_W + POS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FLD_W = 3 * DATA_W + MATCH_W + STAT_W + LEN_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_FLD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_END   = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_END    = 3'd4,
    CMD_ERASE_ALL  = 3'd5,
    CMD_COUNT      = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

endpackage

[design/ole_ram.sv]
module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ordered_list_engine.sv]
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  command, value, position
// m_axis   out  m_axis_tvalid/m_axis_tready  popped_value, match_count, status,
//                                            length, front_value, back_value
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Push/insert moves the entries from the position up one place, one entry
// moved per cycle; pop front, erase and count scan the list, one entry read
// per cycle through the single RAM read port and one shared 32-bit
// comparator; pop end reads the last entry; all end reading front and back.
// Reset clears the state, the count and the valid flags; RAM contents past the count are never used.
// A result waits in the output register; the next item is taken meanwhile and
// only its final step waits for m_axis_tready.
module ordered_list_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[2:0], value[34:3], position[39:35]
  input  logic [ole_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // popped_value[31:0], match_count[36:32], status[38:37], length[43:39],
  // front_value[75:44], back_value[107:76], zero[111:108]
  output logic [ole_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned IDX_W  = ole_pkg::IDX_W;
  localparam int unsigned CNT_W  = ole_pkg::CNT_W;
  localparam int unsigned DATA_W = ole_pkg::DATA_W;
  localparam int unsigned CMP_W  = ole_pkg::CMP_W;
  localparam int unsigned CMD_W  = ole_pkg::CMD_W;
  localparam int unsigned POS_W  = ole_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_POPE,
    S_POPE_W,
    S_FRONT,
    S_BACK,
    S_FIN
  } state_e;

  state_e                          state_q, state_d;
  ole_pkg::cmd_e                   cmd_q, cmd_d;
  ole_pkg::status_e                status_q, status_d;
  logic [DATA_W-1:0]               val_q, val_d;
  logic [IDX_W-1:0]                idx_q, idx_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [CNT_W-1:0]                rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]                wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]                kept_q, kept_d;
  logic [CNT_W-1:0]                left_q, left_d;
  logic [CNT_W-1:0]                match_q, match_d;
  logic                            vld_q, vld_d;
  logic                            first_q, first_d;
  logic [DATA_W-1:0]               popped_q, popped_d;
  logic [DATA_W-1:0]               front_q, front_d;
  logic                            m_valid_q, m_valid_d;
  logic [ole_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic                            ram_we, ram_re;
  logic [IDX_W-1:0]                ram_waddr, ram_raddr;
  logic [DATA_W-1:0]               ram_wdata, ram_rdata;

  ole_pkg::cmd_e                   in_cmd;
  logic [DATA_W-1:0]               in_val;
  logic [POS_W-1:0]                in_pos;
  logic                            accept;
  logic                            is_full, is_empty;
  logic                            eq, drop;
  logic [CNT_W-1:0]                kept_nx;
  logic [DATA_W-1:0]               back_val;

  assign in_cmd   = ole_pkg::cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign in_val   = s_axis_tdata[CMD_W+DATA_W-1:CMD_W];
  assign in_pos   = s_axis_tdata[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_full  = (cnt_q == CNT_W'(ole_pkg::DEPTH));
  assign is_empty = (cnt_q == '0);
  assign eq       = (ram_rdata == val_q);
  assign back_val = is_empty ? '1 : ram_rdata;

  ole_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ole_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    status_d  = status_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    kept_d    = kept_q;
    left_d    = left_q;
    match_d   = match_q;
    vld_d     = vld_q;
    first_d   = first_q;
    popped_d  = popped_q;
    front_d   = front_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    drop      = 1'b0;
    kept_nx   = kept_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = in_cmd;
          val_d    = in_val;
          status_d = ole_pkg::ST_OK;
          match_d  = '0;
          popped_d = '0;
          rd_ptr_d = '0;
          kept_d   = '0;
          vld_d    = 1'b0;
          first_d  = 1'b1;
          state_d  = S_FRONT;
          unique case (in_cmd) inside
            ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_END: begin
              if (is_full) begin
                status_d = ole_pkg::ST_FULL;
              end else begin
                idx_d    = (in_cmd == ole_pkg::CMD_PUSH_FRONT) ? '0 : IDX_W'(cnt_q);
                left_d   = (in_cmd == ole_pkg::CMD_PUSH_FRONT) ? cnt_q : '0;
                rd_ptr_d = cnt_q - 1'b1;
                state_d  = S_SHIFT;
              end
            end
            ole_pkg::CMD_INSERT_AT: begin
              if (CMP_W'(in_pos) > CMP_W'(cnt_q)) begin
                status_d = ole_pkg::ST_BAD_IDX;
              end else if (is_full) begin
                status_d = ole_pkg::ST_FULL;
              end else begin
                idx_d    = IDX_W'(in_pos);
                left_d   = CNT_W'(CMP_W'(cnt_q) - CMP_W'(in_pos));
                rd_ptr_d = cnt_q - 1'b1;
                state_d  = S_SHIFT;
              end
            end
            ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_POP_END: begin
              if (is_empty) begin
                popped_d = '1;
                status_d = ole_pkg::ST_EMPTY;
              end else begin
                state_d = (in_cmd == ole_pkg::CMD_POP_FRONT) ? S_SCAN : S_POPE;
              end
            end
            ole_pkg::CMD_ERASE_ALL, ole_pkg::CMD_COUNT: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_FRONT;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read entry rd, write it one place up on the next cycle
        ram_we    = vld_q;
        ram_waddr = wr_ptr_q;
        if (left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q[IDX_W-1:0];
          wr_ptr_d  = rd_ptr_q[IDX_W-1:0] + 1'b1;
          rd_ptr_d  = rd_ptr_q - 1'b1;
          left_d    = left_q - 1'b1;
          vld_d     = 1'b1;
        end else begin
          vld_d   = 1'b0;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_FRONT;
      end

      S_SCAN: begin
        if (vld_q) begin
          drop = (cmd_q == ole_pkg::CMD_POP_FRONT) ? first_q : eq;
          if (cmd_q == ole_pkg::CMD_POP_FRONT && first_q) begin
            popped_d = ram_rdata;
          end
          first_d = 1'b0;
          if (drop && cmd_q != ole_pkg::CMD_POP_FRONT) begin
            match_d = match_q + 1'b1;
          end
          if (!drop && cmd_q != ole_pkg::CMD_COUNT) begin
            ram_we    = 1'b1;
            ram_waddr = kept_q[IDX_W-1:0];
            kept_nx   = kept_q + 1'b1;
          end
        end
        kept_d = kept_nx;
        if (rd_ptr_q != cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q[IDX_W-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
          vld_d     = 1'b1;
        end else begin
          vld_d   = 1'b0;
          cnt_d   = (cmd_q == ole_pkg::CMD_COUNT) ? cnt_q : kept_nx;
          state_d = S_FRONT;
        end
      end

      S_POPE: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(cnt_q - 1'b1);
        state_d   = S_POPE_W;
      end

      S_POPE_W: begin
        popped_d = ram_rdata;
        cnt_d    = cnt_q - 1'b1;
        state_d  = S_FRONT;
      end

      S_FRONT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_BACK;
      end

      S_BACK: begin
        front_d   = is_empty ? '1 : ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(cnt_q - 1'b1);
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{ole_pkg::OUT_PAD_W{1'b0}}, back_val, front_q,
                       ole_pkg::LEN_W'(cnt_q), status_q,
                       ole_pkg::MATCH_W'(match_q), popped_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      vld_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      vld_q     <= vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    kept_q   <= kept_d;
    left_q   <= left_d;
    match_q  <= match_d;
    first_q  <= first_d;
    popped_q <= popped_d;
    front_q  <= front_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ole_pkg::DEPTH))
    else $error("entry count above capacity");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |-> cnt_q < CNT_W'(ole_pkg::DEPTH))
    else $error("insert into full list");

  a_grow_only_on_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_PUT |=> cnt_q <= $past(cnt_q))
    else $error("count grew outside insert step");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> CNT_W'(ram_waddr) <= cnt_q)
    else $error("RAM write beyond list end");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && m_valid_q && !m_axis_tready |=> state_q == S_FIN)
    else $error("result dropped over a pending one");

endmodule

[verif/ordered_list_engine_tb.sv]
`timescale 1ns / 100ps

module ordered_list_engine_tb;

  localparam logic [ole_pkg::CMD_W-1:0]  CMD_UNUSED     = 3'd7;
  localparam logic [ole_pkg::DATA_W-1:0] NEG_ONE        = 32'hFFFF_FFFF;
  localparam logic [ole_pkg::DATA_W-1:0] MAX_POS        = 32'h7FFF_FFFF;
  localparam logic [ole_pkg::DATA_W-1:0] MIN_NEG        = 32'h8000_0000;
  localparam int                         RANDOM_ITEMS   = 1700;
  localparam int                         HOLD_AT        = 700;
  localparam int                         HOLD_CYCLES    = 400;
  localparam int                         WATCHDOG_LIMIT = 4000;
  localparam int                         DRAIN_CYCLES   = 40;

  // same layout as m_axis_tdata, highest field first
  typedef struct packed {
    logic [ole_pkg::DATA_W-1:0]  back;
    logic [ole_pkg::DATA_W-1:0]  front;
    logic [ole_pkg::LEN_W-1:0]   length;
    ole_pkg::status_e            status;
    logic [ole_pkg::MATCH_W-1:0] hits;
    logic [ole_pkg::DATA_W-1:0]  popped;
  } list_result_t;

  typedef struct {
    logic [ole_pkg::CMD_W-1:0]  op;
    logic [ole_pkg::DATA_W-1:0] val;
    logic [ole_pkg::POS_W-1:0]  pos;
    int                         reps;
    bit                         typed;
    list_result_t               res;
  } stim_row_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ole_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ole_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [ole_pkg::DATA_W-1:0] list_q[$];
  list_result_t               expected_q[$];
  int                         fails      = 0;
  int                         idle_count = 0;
  bit                         src_quiet  = 1'b0;
  bit                         sink_quiet = 1'b0;

  ordered_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_command(input logic [ole_pkg::CMD_W-1:0] op,
                                                 input logic [ole_pkg::DATA_W-1:0] val,
                                                 input logic [ole_pkg::POS_W-1:0] pos);
    list_result_t               r;
    logic [ole_pkg::DATA_W-1:0] kept[$];
    r = '0;
    r.status = ole_pkg::ST_OK;
    case (op) inside
      ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_END: begin
        if (list_q.size() >= ole_pkg::DEPTH) r.status = ole_pkg::ST_FULL;
        else if (op == ole_pkg::CMD_PUSH_FRONT) list_q.insert(0, val);
        else list_q.push_back(val);
      end
      ole_pkg::CMD_INSERT_AT: begin
        if (int'(pos) > list_q.size()) r.status = ole_pkg::ST_BAD_IDX;
        else if (list_q.size() >= ole_pkg::DEPTH) r.status = ole_pkg::ST_FULL;
        else list_q.insert(int'(pos), val);
      end
      ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_POP_END: begin
        if (list_q.size() == 0) begin
          r.popped = NEG_ONE;
          r.status = ole_pkg::ST_EMPTY;
        end else if (op == ole_pkg::CMD_POP_FRONT) begin
          r.popped = list_q[0];
          list_q.delete(0);
        end else begin
          r.popped = list_q.pop_back();
        end
      end
      ole_pkg::CMD_ERASE_ALL: begin
        foreach (list_q[i]) begin
          if (list_q[i] == val) r.hits++;
          else kept.push_back(list_q[i]);
        end
        list_q = kept;
      end
      ole_pkg::CMD_COUNT: begin
        foreach (list_q[i]) if (list_q[i] == val) r.hits++;
      end
      default: ;
    endcase
    r.length = ole_pkg::LEN_W'(list_q.size());
    r.front  = (list_q.size() != 0) ? list_q[0] : NEG_ONE;
    r.back   = (list_q.size() != 0) ? list_q[$] : NEG_ONE;
    return r;
  endfunction

  task automatic send_command(input logic [ole_pkg::CMD_W-1:0] op,
                              input logic [ole_pkg::DATA_W-1:0] val,
                              input logic [ole_pkg::POS_W-1:0] pos, input bit typed,
                              input list_result_t res);
    int           gap;
    list_result_t predicted;
    gap = src_quiet ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, val, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_command(op, val, pos);
    expected_q.push_back(typed ? res : predicted);
  endtask

  task automatic check_result(input list_result_t got);
    list_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: %h", got);
      fails++;
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      if (got.popped !== want.popped) begin
        $error("popped_value: expected %0d, got %0d", $signed(want.popped), $signed(got.popped));
        fails++;
      end
      if (got.hits !== want.hits) begin
        $error("match_count: expected %0d, got %0d", want.hits, got.hits);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        fails++;
      end
      if (got.front !== want.front) begin
        $error("front_value: expected %0d, got %0d", $signed(want.front), $signed(got.front));
        fails++;
      end
      if (got.back !== want.back) begin
        $error("back_value: expected %0d, got %0d", $signed(want.back), $signed(got.back));
        fails++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    int seen;
    seen = 0;
    @(posedge rst_ni);
    forever begin
      if (seen == HOLD_AT) stall = HOLD_CYCLES;
      else stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      seen++;
      check_result(m_axis_tdata[ole_pkg::OUT_FLD_W-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("FAIL ordered_list_engine");
        $finish;
      end
    end
  end

  initial begin : command_source
    stim_row_t                  rows[$];
    logic [ole_pkg::CMD_W-1:0]  op;
    logic [ole_pkg::DATA_W-1:0] val;
    logic [ole_pkg::POS_W-1:0]  pos;
    int                         roll;
    bit                         filling;

    // res: back, front, length, status, hits, popped
    rows = '{
      '{ole_pkg::CMD_POP_FRONT,  32'd0,   5'd0,  1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_EMPTY, 5'd0, NEG_ONE}},
      '{ole_pkg::CMD_POP_END,    32'd0,   5'd0,  1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_EMPTY, 5'd0, NEG_ONE}},
      '{ole_pkg::CMD_ERASE_ALL,  32'd5,   5'd0,  1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_COUNT,      32'd5,   5'd0,  1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_INSERT_AT,  32'd1,   5'd1,  1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_BAD_IDX, 5'd0, 32'd0}},
      '{CMD_UNUSED,              NEG_ONE, 5'd31, 1, 1'b1,
        '{NEG_ONE, NEG_ONE, 5'd0, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_PUSH_FRONT, MAX_POS, 5'd0,  1, 1'b1,
        '{MAX_POS, MAX_POS, 5'd1, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_PUSH_END,   MIN_NEG, 5'd0,  1, 1'b1,
        '{MIN_NEG, MAX_POS, 5'd2, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_INSERT_AT,  NEG_ONE, 5'd1,  1, 1'b1,
        '{MIN_NEG, MAX_POS, 5'd3, ole_pkg::ST_OK, 5'd0, 32'd0}},
      '{ole_pkg::CMD_INSERT_AT,  32'd0,   5'd31, 1, 1'b1,
        '{MIN_NEG, MAX_POS, 5'd3, ole_pkg::ST_BAD_IDX, 5'd0, 32'd0}},
      '{ole_pkg::CMD_INSERT_AT,  32'd0,   5'd3,  1, 1'b0, '0},
      '{ole_pkg::CMD_INSERT_AT,  MIN_NEG, 5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_COUNT,      MIN_NEG, 5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_PUSH_END,   MIN_NEG, 5'd0, 11, 1'b0, '0},
      '{ole_pkg::CMD_PUSH_FRONT, 32'd1,   5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_PUSH_END,   32'd2,   5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_INSERT_AT,  32'd3,   5'd16, 1, 1'b0, '0},
      '{ole_pkg::CMD_INSERT_AT,  32'd3,   5'd17, 1, 1'b0, '0},
      '{ole_pkg::CMD_COUNT,      MIN_NEG, 5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_ERASE_ALL,  MIN_NEG, 5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_POP_FRONT,  32'd0,   5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_POP_END,    32'd0,   5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_POP_FRONT,  32'd0,   5'd0,  1, 1'b0, '0},
      '{ole_pkg::CMD_POP_END,    32'd0,   5'd0,  1, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      repeat (rows[i].reps)
        send_command(rows[i].op, rows[i].val, rows[i].pos, rows[i].typed, rows[i].res);
    end

    // alternate between growing to full and draining to empty
    filling = 1'b1;
    repeat (RANDOM_ITEMS) begin
      if (list_q.size() >= ole_pkg::DEPTH) filling = 1'b0;
      else if (list_q.size() == 0) filling = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 5) op = ole_pkg::CMD_ERASE_ALL;
      else if (roll < 13) op = ole_pkg::CMD_COUNT;
      else if (roll < 15) op = CMD_UNUSED;
      else if ((roll < 67) == filling) begin
        case ($urandom_range(0, 2))
          0: op = ole_pkg::CMD_PUSH_FRONT;
          1: op = ole_pkg::CMD_PUSH_END;
          default: op = ole_pkg::CMD_INSERT_AT;
        endcase
      end else begin
        op = $urandom_range(0, 1) ? ole_pkg::CMD_POP_FRONT : ole_pkg::CMD_POP_END;
      end

      roll = $urandom_range(0, 9);
      if (roll < 5) val = $urandom_range(0, 7);
      else if (roll < 7) begin
        case ($urandom_range(0, 2))
          0: val = MIN_NEG;
          1: val = MAX_POS;
          default: val = NEG_ONE;
        endcase
      end else val = $urandom();

      if ($urandom_range(0, 9) < 8) pos = ole_pkg::POS_W'($urandom_range(0, list_q.size()));
      else pos = ole_pkg::POS_W'($urandom_range(0, 31));

      send_command(op, val, pos, 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS ordered_list_engine");
    end else begin
      $display("FAIL ordered_list_engine");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ole_pkg.sv
design/ole_ram.sv
design/ordered_list_engine.sv
verif/ordered_list_engine_tb.sv
